// File: hw/rtl/text_to_integer_radix_parser_unit_defines.svh
`ifndef TEXT_TO_INTEGER_RADIX_PARSER_UNIT_DEFINES_SVH
`define TEXT_TO_INTEGER_RADIX_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define TTIRP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttirp check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define TTIRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttirp check failed");

`endif

// File: hw/rtl/ttirp_pkg.sv
package ttirp_pkg;

    localparam int unsigned MAX_STRING_LEN = 65535;
    localparam int unsigned OFFSET_W       = 16;
    localparam int unsigned VALUE_W        = 64;
    localparam int unsigned RADIX_W        = 6;

    localparam logic [OFFSET_W-1:0] OFFSET_LIMIT =
        (MAX_STRING_LEN > 65535) ? 16'hFFFF : OFFSET_W'(MAX_STRING_LEN);

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    typedef enum logic [5:0] {
        PH_SPACE  = 6'b000001,
        PH_SIGNED = 6'b000010,
        PH_ZERO   = 6'b000100,
        PH_DIGITS = 6'b001000,
        PH_DONE   = 6'b010000,
        PH_BAD    = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [OFFSET_W-1:0] end_offset;
        logic                overflow;
        logic                bad_base;
    } result_t;

    typedef struct packed {
        phase_t              phase;
        logic [VALUE_W-1:0]  acc;
        logic [RADIX_W-1:0]  base;
        logic                minus;
        logic                ovf;
        logic [OFFSET_W-1:0] pos;
        logic [OFFSET_W-1:0] dend;
    } state_t;

    localparam state_t STATE_CLEAR = '{
        phase: PH_SPACE,
        acc:   '0,
        base:  '0,
        minus: 1'b0,
        ovf:   1'b0,
        pos:   '0,
        dend:  '0
    };

endpackage

// File: hw/rtl/text_to_integer_radix_parser_unit.sv
// The last byte sits in the byte register, then its result is registered, raising
// result_valid. Throughput: 1 byte per cycle; the accumulate step (acc * base +
// digit, 64x6 multiply with overflow check) is combinational between the byte
// register and the state/result registers. A last byte waits while the result is
// unaccepted. Reset: clears parse state and output valid; radix returns to 10.
module text_to_integer_radix_parser_unit
    import ttirp_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_STRING_LEN
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  item_t              item,
    output logic               result_valid,
    input  logic               result_ready,
    output result_t            result,
    input  logic               radix_valid,
    output logic               radix_ready,
    input  logic [RADIX_W-1:0] radix
);

    item_t              item_reg;
    logic               item_valid_reg;
    logic               item_valid_next;
    result_t            result_reg;
    logic               result_valid_reg;
    logic               result_valid_next;
    state_t             state_reg;
    state_t             state_next;
    logic [RADIX_W-1:0] radix_reg;
    logic [RADIX_W-1:0] radix_next;

    state_t             step_state;
    result_t            step_result;
    logic               out_free;
    logic               fire;
    logic               emit;

    ttirp_step #(
        .MAX_LEN (MAX_LEN)
    ) u_step (
        .cur   (state_reg),
        .item  (item_reg),
        .radix (radix_reg),
        .nxt   (step_state),
        .res   (step_result)
    );

    assign out_free    = !result_valid_reg || result_ready;
    assign fire        = item_valid_reg && (!item_reg.last || out_free);
    assign emit        = fire && item_reg.last;
    assign item_ready  = !item_valid_reg || fire;
    assign radix_ready = 1'b1;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        item_valid_next   = item_ready ? item_valid : item_valid_reg;
        result_valid_next = emit ? 1'b1 : (result_ready ? 1'b0 : result_valid_reg);
        state_next        = state_reg;
        if (fire)
            state_next = item_reg.last ? STATE_CLEAR : step_state;
        radix_next = radix_valid ? radix : radix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= STATE_CLEAR;
            radix_reg        <= RADIX_RESET;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
            state_reg        <= state_next;
            radix_reg        <= radix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready)
            item_reg <= item;
        if (emit)
            result_reg <= step_result;
    end

endmodule

// File: hw/rtl/ttirp_step.sv
module ttirp_step
    import ttirp_pkg::*;
#(
    parameter int unsigned MAX_LEN = MAX_STRING_LEN
)
(
    input  state_t             cur,
    input  item_t              item,
    input  logic [RADIX_W-1:0] radix,
    output state_t             nxt,
    output result_t            res
);

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] DIGIT_NONE = 8'd255;

    localparam logic [OFFSET_W-1:0] POS_LIMIT =
        (MAX_LEN > 65535) ? 16'hFFFF : OFFSET_W'(MAX_LEN);

    function automatic logic [7:0] digit_value(input logic [7:0] ch);
        logic [7:0] v;
        v = DIGIT_NONE;
        case (ch) inside
            [8'h30:8'h39]: v = ch - 8'h30;
            [8'h61:8'h7A]: v = ch - 8'h61 + 8'd10;
            [8'h41:8'h5A]: v = ch - 8'h41 + 8'd10;
            default:       v = DIGIT_NONE;
        endcase
        return v;
    endfunction

    function automatic logic is_blank(input logic [7:0] ch);
        logic b;
        case (ch) inside
            8'h20, [8'h09:8'h0D]: b = 1'b1;
            default:              b = 1'b0;
        endcase
        return b;
    endfunction

    logic                   first;
    logic [RADIX_W-1:0]     base_eff;
    logic [RADIX_W-1:0]     td_base;
    phase_t                 ph;
    logic [7:0]             dv;
    logic                   digit_ok;
    logic [VALUE_W+5:0]     prod;
    logic [OFFSET_W-1:0]    pos_inc;
    logic                   zero_pref;
    logic                   after_sign;
    logic                   take;
    logic                   bad;

    always_comb
    begin
        first     = (cur.pos == '0) && (cur.phase == PH_SPACE);
        base_eff  = first ? radix : cur.base;
        ph        = (first && (radix == 6'd1 || radix > RADIX_MAX)) ? PH_BAD : cur.phase;
        dv        = digit_value(item.char_in);
        td_base   = (base_eff != '0) ? base_eff : ((ph == PH_ZERO) ? 6'd8 : 6'd10);
        digit_ok  = (td_base >= 6'd2) && (td_base <= RADIX_MAX) && (dv < 8'(td_base));
        prod      = (VALUE_W+6)'(cur.acc) * (VALUE_W+6)'(td_base)
                  + (VALUE_W+6)'(dv[5:0]);
        pos_inc   = (cur.pos >= POS_LIMIT) ? POS_LIMIT : cur.pos + 16'd1;
        zero_pref = (item.char_in == CH_ZERO) && (base_eff == '0 || base_eff == 6'd16);

        nxt        = cur;
        nxt.base   = base_eff;
        nxt.phase  = ph;
        after_sign = 1'b0;
        take       = 1'b0;

        case (ph)
            PH_SPACE:
            begin
                if (is_blank(item.char_in))
                begin
                end
                else if (item.char_in == CH_MINUS)
                begin
                    nxt.minus = 1'b1;
                    nxt.phase = PH_SIGNED;
                end
                else if (item.char_in == CH_PLUS)
                begin
                    nxt.phase = PH_SIGNED;
                end
                else
                begin
                    after_sign = 1'b1;
                end
            end
            PH_SIGNED:
            begin
                after_sign = 1'b1;
            end
            PH_ZERO:
            begin
                if (item.char_in == CH_LOW_X || item.char_in == CH_UP_X)
                begin
                    nxt.base  = 6'd16;
                    nxt.phase = PH_DIGITS;
                end
                else
                begin
                    take = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                take = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (after_sign)
        begin
            if (zero_pref)
            begin
                nxt.acc   = '0;
                nxt.dend  = pos_inc;
                nxt.phase = PH_ZERO;
            end
            else
            begin
                take = 1'b1;
            end
        end

        if (take)
        begin
            nxt.base = td_base;
            if (!digit_ok)
            begin
                nxt.phase = PH_DONE;
            end
            else
            begin
                if (cur.ovf || prod[VALUE_W+5:VALUE_W] != '0)
                    nxt.ovf = 1'b1;
                else
                    nxt.acc = prod[VALUE_W-1:0];
                nxt.dend  = pos_inc;
                nxt.phase = PH_DIGITS;
            end
        end

        nxt.pos = pos_inc;

        bad              = (nxt.phase == PH_BAD);
        res.bad_base     = bad;
        res.overflow     = !bad && nxt.ovf;
        res.end_offset   = bad ? '0 : nxt.dend;
        if (bad)
            res.value = '0;
        else if (nxt.ovf)
            res.value = '1;
        else if (nxt.minus)
            res.value = '0 - nxt.acc;
        else
            res.value = nxt.acc;
    end

endmodule

// File: hw/rtl/ttirp_checker.sv
`include "text_to_integer_radix_parser_unit_defines.svh"

module ttirp_checker
    import ttirp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input item_t              item,
    input logic               result_valid,
    input logic               result_ready,
    input result_t            result,
    input logic               radix_valid,
    input logic               radix_ready,
    input logic [RADIX_W-1:0] radix
);

    // stalled result transaction must hold
    `TTIRP_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

    `TTIRP_ASSERT_NOW(a_bad_base_zero, result_valid && result.bad_base, result.value == '0 && result.end_offset == '0 && !result.overflow)

    `TTIRP_ASSERT_NOW(a_overflow_ones, result_valid && result.overflow, (&result.value) && !result.bad_base)

endmodule

bind text_to_integer_radix_parser_unit ttirp_checker u_ttirp_checker (.*);

// File: dv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import ttirp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 4;
    localparam int END_CYCLES     = 10;
    localparam int RANDOM_BYTES   = 1200;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_ready;
    item_t              item         = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    result_t            result;
    logic               radix_valid  = 1'b0;
    logic               radix_ready;
    logic [RADIX_W-1:0] radix        = '0;

    text_to_integer_radix_parser_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .radix_valid  (radix_valid),
        .radix_ready  (radix_ready),
        .radix        (radix)
    );

    // parser mirror
    logic [RADIX_W-1:0]  radix_setting = RADIX_RESET;
    phase_t              num_phase     = PH_SPACE;
    logic [VALUE_W-1:0]  num_acc       = '0;
    logic [RADIX_W-1:0]  num_base      = '0;
    logic                num_minus     = 1'b0;
    logic                num_ovf       = 1'b0;
    logic [OFFSET_W-1:0] num_pos       = '0;
    logic [OFFSET_W-1:0] num_dend      = '0;

    logic [7:0] draft[$];
    item_t      staged_text[$];
    item_t      text_bytes[$];
    result_t    expected_numbers[$];

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int hold_requests     = 0;
    int holds_seen        = 0;
    int hold_left         = 0;
    int quiet_cycles      = 0;
    int mismatch_count    = 0;
    int bytes_taken       = 0;
    int numbers_checked   = 0;
    int radix_writes      = 0;
    int random_bytes      = 0;

    function automatic logic [7:0] digit_of(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") return ch - "0";
        if (ch >= "a" && ch <= "z") return ch - "a" + 8'd10;
        if (ch >= "A" && ch <= "Z") return ch - "A" + 8'd10;
        return 8'd255;
    endfunction

    function automatic bit is_blank(input logic [7:0] ch);
        return ch == 8'h20 || ch == 8'h09 || ch == 8'h0A || ch == 8'h0D ||
               ch == 8'h0B || ch == 8'h0C;
    endfunction

    function automatic logic [7:0] blank_char(input int k);
        case (k)
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0A;
            3: return 8'h0B;
            4: return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    function automatic logic [OFFSET_W-1:0] bump_offset(input logic [OFFSET_W-1:0] p);
        return ({1'b0, p} + 17'd1 > {1'b0, OFFSET_LIMIT}) ? OFFSET_LIMIT : p + 1'b1;
    endfunction

    function automatic void take_digit(input logic [7:0] ch);
        logic [7:0]         d;
        logic [VALUE_W-1:0] wide_base;
        logic [VALUE_W-1:0] cutoff;
        logic [VALUE_W-1:0] cutlim;
        d = digit_of(ch);
        if (num_base < 2 || num_base > RADIX_MAX || d >= num_base)
        begin
            num_phase = PH_DONE;
            return;
        end
        wide_base = {{(VALUE_W-RADIX_W){1'b0}}, num_base};
        cutoff = {VALUE_W{1'b1}} / wide_base;
        cutlim = {VALUE_W{1'b1}} % wide_base;
        if (num_ovf || num_acc > cutoff || (num_acc == cutoff && {56'b0, d} > cutlim))
            num_ovf = 1'b1;
        else
            num_acc = num_acc * wide_base + {56'b0, d};
        num_dend = bump_offset(num_pos);
        num_phase = PH_DIGITS;
    endfunction

    function automatic void after_sign(input logic [7:0] ch);
        if (ch == "0" && (num_base == 0 || num_base == 16))
        begin
            num_acc = '0;
            num_dend = bump_offset(num_pos);
            num_phase = PH_ZERO;
        end
        else
        begin
            if (num_base == 0)
                num_base = 10;
            take_digit(ch);
        end
    endfunction

    // advances the mirror by one byte; returns 1 when a number is due
    function automatic bit parse_byte(input item_t it, output result_t res);
        res = '0;
        if (num_pos == 0 && num_phase == PH_SPACE)
        begin
            num_base = radix_setting;
            if (num_base == 1 || num_base > RADIX_MAX)
                num_phase = PH_BAD;
        end
        case (num_phase)
            PH_SPACE:
            begin
                if (it.char_in == "-")
                begin
                    num_minus = 1'b1;
                    num_phase = PH_SIGNED;
                end
                else if (it.char_in == "+")
                    num_phase = PH_SIGNED;
                else if (!is_blank(it.char_in))
                    after_sign(it.char_in);
            end
            PH_SIGNED: after_sign(it.char_in);
            PH_ZERO:
            begin
                if (it.char_in == "x" || it.char_in == "X")
                begin
                    num_base = 16;
                    num_phase = PH_DIGITS;
                end
                else
                begin
                    if (num_base == 0)
                        num_base = 8;
                    take_digit(it.char_in);
                end
            end
            PH_DIGITS: take_digit(it.char_in);
            default: ;
        endcase
        num_pos = bump_offset(num_pos);
        if (!it.last)
            return 1'b0;
        if (num_phase == PH_BAD)
            res.bad_base = 1'b1;
        else
        begin
            res.value = num_ovf ? '1 : (num_minus ? -num_acc : num_acc);
            res.end_offset = num_dend;
            res.overflow = num_ovf;
        end
        num_phase = PH_SPACE;
        num_acc = '0;
        num_base = '0;
        num_minus = 1'b0;
        num_ovf = 1'b0;
        num_pos = '0;
        num_dend = '0;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    initial
    begin
        forever #1 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        result_t res;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                bytes_taken++;
                if (parse_byte(item, res))
                    expected_numbers.push_back(res);
            end
            if (!item_valid || item_ready)
            begin
                if (text_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    item <= text_bytes.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : watch_numbers
        result_t want;
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                numbers_checked++;
                if (expected_numbers.size() == 0)
                    flag_mismatch($sformatf("unexpected transaction, value %h", result.value));
                else
                begin
                    want = expected_numbers.pop_front();
                    if (result.value !== want.value)
                        flag_mismatch($sformatf("value %h, want %h", result.value, want.value));
                    if (result.end_offset !== want.end_offset)
                        flag_mismatch($sformatf("end_offset %0d, want %0d",
                                                result.end_offset, want.end_offset));
                    if (result.overflow !== want.overflow)
                        flag_mismatch($sformatf("overflow %b, want %b",
                                                result.overflow, want.overflow));
                    if (result.bad_base !== want.bad_base)
                        flag_mismatch($sformatf("bad_base %b, want %b",
                                                result.bad_base, want.bad_base));
                end
            end
            if (hold_requests != holds_seen)
            begin
                holds_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
            (radix_valid && radix_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: %0d cycles without a transaction", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            draft.push_back(s[i]);
    endtask

    task automatic close_string(input bit mark_last);
        item_t t;
        for (int i = 0; i < draft.size(); i++)
        begin
            t.char_in = draft[i];
            t.last = mark_last && (i == draft.size() - 1);
            staged_text.push_back(t);
        end
        draft.delete();
    endtask

    task automatic flush_text();
        @(negedge clk);
        while (staged_text.size() != 0)
            text_bytes.push_back(staged_text.pop_front());
    endtask

    task automatic wait_idle();
        while (text_bytes.size() != 0 || item_valid)
            @(posedge clk);
        while (expected_numbers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] v);
        @(posedge clk);
        radix_valid <= 1'b1;
        radix <= v;
        do @(posedge clk); while (!radix_ready);
        radix_valid <= 1'b0;
        radix_setting = v;
        radix_writes++;
    endtask

    task automatic stage_random_string(input logic [RADIX_W-1:0] r);
        int         n;
        int         eff;
        int         d;
        logic [7:0] c;
        if ($urandom_range(99) < 12)
        begin
            n = $urandom_range(1, 6);
            repeat (n) draft.push_back(8'($urandom_range(255)));
        end
        else
        begin
            repeat ($urandom_range(0, 2)) draft.push_back(blank_char($urandom_range(5)));
            case ($urandom_range(3))
                0: draft.push_back("-");
                1: draft.push_back("+");
                default: ;
            endcase
            eff = r;
            if ((r == 0 || r == 16) && $urandom_range(2) == 0)
            begin
                draft.push_back("0");
                draft.push_back($urandom_range(1) ? "x" : "X");
                eff = 16;
            end
            else if (r == 0)
            begin
                if ($urandom_range(1))
                begin
                    draft.push_back("0");
                    eff = 8;
                end
                else
                    eff = 10;
            end
            if (eff < 2 || eff > RADIX_MAX)
                eff = 10;
            n = ($urandom_range(4) == 0) ? $urandom_range(15, 70) : $urandom_range(0, 8);
            for (int i = 0; i < n; i++)
            begin
                d = $urandom_range(eff - 1);
                if (d < 10)
                    c = 8'("0" + d);
                else
                    c = 8'(($urandom_range(1) ? "a" : "A") + d - 10);
                draft.push_back(c);
            end
            if ($urandom_range(2) == 0)
                repeat ($urandom_range(1, 3)) draft.push_back(8'($urandom_range(255)));
        end
        if (draft.size() == 0)
            draft.push_back(8'($urandom_range(255)));
        random_bytes += draft.size();
        close_string(1'b1);
    endtask

    initial
    begin
        logic [RADIX_W-1:0] next_radix;
        int                 segment;
        segment = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        sender_idle_pct = 13;
        receiver_idle_pct = 48;

        // radix at its reset value
        draft.push_back(8'h20);
        draft.push_back(8'h09);
        draft.push_back(8'h0A);
        draft.push_back(8'h0B);
        draft.push_back(8'h0C);
        draft.push_back(8'h0D);
        add_text("-12");
        close_string(1'b1);
        add_text("+7Z9");
        close_string(1'b1);
        draft.push_back(8'hFF);
        close_string(1'b1);
        draft.push_back(8'h00);
        close_string(1'b1);
        add_text("5");
        draft.push_back(8'h00);
        add_text("3");
        close_string(1'b1);
        flush_text();
        wait_idle();

        write_radix(0);
        add_text("0x1fA");
        close_string(1'b1);
        add_text("-0Xg");
        close_string(1'b1);
        add_text("0178");
        close_string(1'b1);
        add_text("9");
        close_string(1'b1);
        // new radix lands mid-string, applies to the next one
        add_text(" 4");
        close_string(1'b0);
        flush_text();
        wait_idle();
        write_radix(16);
        add_text("f");
        close_string(1'b1);
        add_text("Ff");
        close_string(1'b1);
        add_text("0x10");
        close_string(1'b1);
        flush_text();
        wait_idle();

        write_radix(1);
        add_text("12");
        close_string(1'b1);
        flush_text();
        wait_idle();
        write_radix(63);
        add_text("-7");
        close_string(1'b1);
        flush_text();
        wait_idle();
        write_radix(2);
        add_text("1012");
        close_string(1'b1);
        flush_text();
        wait_idle();
        write_radix(RADIX_MAX);
        add_text("-3W5E11264SGSF");
        close_string(1'b1);
        add_text("3w5e11264sgsg");
        close_string(1'b1);
        flush_text();
        wait_idle();

        while (random_bytes < RANDOM_BYTES)
        begin
            if (random_bytes < RANDOM_BYTES / 3)
            begin
                sender_idle_pct = 13;
                receiver_idle_pct = 48;
            end
            else if (random_bytes < 2 * RANDOM_BYTES / 3)
            begin
                sender_idle_pct = 48;
                receiver_idle_pct = 13;
            end
            else
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            case ($urandom_range(9))
                0: next_radix = 0;
                1: next_radix = 2;
                2: next_radix = RADIX_MAX;
                3: next_radix = 1;
                4: next_radix = RADIX_W'($urandom_range(RADIX_MAX + 1, 63));
                5: next_radix = 16;
                default: next_radix = RADIX_W'($urandom_range(2, RADIX_MAX));
            endcase
            if (segment == 0)
                next_radix = 0;
            write_radix(next_radix);
            repeat ((segment == 0) ? 40 : $urandom_range(8, 25))
                stage_random_string(next_radix);
            flush_text();
            if (segment == 0)
                hold_requests++;
            wait_idle();
            segment++;
        end

        repeat (END_CYCLES) @(posedge clk);
        if (expected_numbers.size() != 0)
            flag_mismatch($sformatf("%0d numbers never arrived", expected_numbers.size()));
        $display("Parsed %0d strings from %0d bytes over %0d radix writes,",
                 numbers_checked, bytes_taken, radix_writes);
        $display("with a %0d-cycle output stall, bad bases and a radix change mid-string.",
                 LONG_HOLD);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ttirp_pkg.sv
hw/rtl/ttirp_step.sv
hw/rtl/text_to_integer_radix_parser_unit.sv
hw/rtl/ttirp_checker.sv
dv/tb_top.sv
